// File: design/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  localparam logic [15:0] LIMIT_RESET = 16'd64;
  localparam int          MAX_BYTES   = 4;

  typedef enum logic [3:0] {
    PH_NORMAL,
    PH_ESC,
    PH_HEX,
    PH_SBS,
    PH_SU,
    PH_SHEX,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_ESC,
    ST_BAD_HEX,
    ST_TRUNC,
    ST_UNPAIRED
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    status_t    status;
    logic       last_result;
  } out_beat_t;

  // Everything one input byte produces: up to four data bytes, then an
  // optional end-of-string status beat. bytes[0] goes out first.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                nbytes;
    logic                      has_status;
    status_t                   status;
  } bundle_t;

endpackage

// File: design/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
// Takes one raw string-content byte per beat on the char channel and returns
// decoded beats on the dec channel: data bytes (is_data=1), then on the byte
// flagged last_byte one status beat (is_data=0, last_result=1). A plain byte
// or simple escape makes one beat; a \uXXXX escape or surrogate pair yields up to 4 UTF-8
// bytes on its final hex digit, and that byte's results drain from the
// result register one beat per cycle while dec_ready is high. The next
// input byte is taken in the same cycle the final pending beat is taken, so
// the block sustains one byte per cycle when each byte makes at most one
// beat and dec_ready stays high; the result register's single-beat drain
// sets that rate. Bytes that make no result (escape prefix, hex digits,
// text after a closing quote, the limit or an error) are still accepted
// every cycle. cfg_wdata sets the output limit in bytes (reset 64); write it
// between strings while no results are pending.
module json_string_unescape_utf8 (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_ready,
  input  jsu_pkg::in_beat_t  char_data,
  output logic               dec_valid,
  input  logic               dec_ready,
  output jsu_pkg::out_beat_t dec_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import jsu_pkg::*;

  logic [15:0] output_limit;
  logic        accept;
  bundle_t     bundle;

  // limit register; no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      output_limit <= cfg_wdata;
    end
  end

  assign accept = char_valid && char_ready;

  // decode happens on the accepted beat; its results land in the queue
  jsu_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (char_data),
    .limit  (output_limit),
    .bundle (bundle)
  );

  jsu_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .bundle    (bundle),
    .can_load  (char_ready),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data)
  );

endmodule

// File: design/jsu_core.sv
// Escape decoder: per-string state registers and next-state/result logic.
module jsu_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  jsu_pkg::in_beat_t beat,
  input  logic [15:0]      limit,
  output jsu_pkg::bundle_t bundle
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef struct packed {
    logic [2:0]                len;
    logic [MAX_BYTES-1:0][7:0] bytes;
  } enc_t;

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp <= 21'h7F) begin
      e.len      = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.len      = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.len      = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.len      = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  phase_t      phase, phase_next;
  logic [15:0] acc, acc_next;
  logic [1:0]  cnt, cnt_next;
  logic [9:0]  hs, hs_next;
  logic [15:0] emitted, emitted_next;
  status_t     err, err_next;

  logic [7:0]  b;
  logic        last;
  logic [4:0]  hv;
  logic [15:0] acc_shift;
  logic        put_cp;
  logic [20:0] cp;
  enc_t        enc;
  logic        fits;
  logic        below;

  assign b     = beat.in_byte;
  assign last  = beat.last_byte;
  assign hv    = hex_value(b);
  assign acc_shift = {acc[11:0], hv[3:0]};
  assign below = emitted < limit;

  always_comb begin
    phase_next   = phase;
    acc_next     = acc;
    cnt_next     = cnt;
    hs_next      = hs;
    emitted_next = emitted;
    err_next     = err;
    put_cp       = 1'b0;
    cp           = '0;
    bundle       = '0;
    bundle.status = ST_OK;

    unique case (phase) inside
      PH_NORMAL: begin
        if (!below || b == CH_QUOTE) begin
          phase_next = PH_DONE;
        end else if (b == CH_BSL) begin
          if (last) begin
            phase_next = PH_ERROR;
            err_next   = ST_TRUNC;
          end else begin
            phase_next = PH_ESC;
          end
        end else begin
          bundle.bytes[0] = b;
          bundle.nbytes   = 3'd1;
          emitted_next    = emitted + 16'd1;
        end
      end
      PH_ESC: begin
        if (b == CH_U) begin
          acc_next = '0;
          cnt_next = '0;
          if (last) begin
            phase_next = PH_ERROR;
            err_next   = ST_TRUNC;
          end else begin
            phase_next = PH_HEX;
          end
        end else begin
          phase_next = PH_NORMAL;
          case (b) inside
            CH_QUOTE, CH_SLASH, CH_BSL: bundle.bytes[0] = b;
            CH_B:    bundle.bytes[0] = 8'h08;
            CH_F:    bundle.bytes[0] = 8'h0C;
            CH_N:    bundle.bytes[0] = 8'h0A;
            CH_R:    bundle.bytes[0] = 8'h0D;
            CH_T:    bundle.bytes[0] = 8'h09;
            default: begin
              phase_next = PH_ERROR;
              err_next   = ST_BAD_ESC;
            end
          endcase
          if (phase_next == PH_NORMAL && below) begin
            bundle.nbytes = 3'd1;
            emitted_next  = emitted + 16'd1;
          end else begin
            bundle.bytes = '0;
          end
        end
      end
      PH_HEX, PH_SHEX: begin
        if (!hv[4]) begin
          phase_next = PH_ERROR;
          err_next   = ST_BAD_HEX;
        end else begin
          acc_next = acc_shift;
          if (cnt != 2'd3) begin
            cnt_next = cnt + 2'd1;
            if (last) begin
              phase_next = PH_ERROR;
              err_next   = ST_TRUNC;
            end
          end else begin
            cnt_next = '0;
            if (phase == PH_SHEX) begin
              put_cp     = 1'b1;
              cp         = 21'h10000 + {1'b0, hs, 10'b0} + {11'b0, acc_shift[9:0]};
              phase_next = PH_NORMAL;
            end else if (acc_shift[15:10] == 6'b110110) begin
              // high surrogate: wait for the low half
              hs_next = acc_shift[9:0];
              if (last) begin
                phase_next = PH_ERROR;
                err_next   = ST_UNPAIRED;
              end else begin
                phase_next = PH_SBS;
              end
            end else begin
              put_cp     = 1'b1;
              cp         = {5'b0, acc_shift};
              phase_next = PH_NORMAL;
            end
          end
        end
      end
      PH_SBS: begin
        if (b != CH_BSL) begin
          phase_next = PH_ERROR;
          err_next   = ST_UNPAIRED;
        end else if (last) begin
          phase_next = PH_ERROR;
          err_next   = ST_TRUNC;
        end else begin
          phase_next = PH_SU;
        end
      end
      PH_SU: begin
        if (b != CH_U) begin
          phase_next = PH_ERROR;
          err_next   = ST_UNPAIRED;
        end else begin
          acc_next = '0;
          cnt_next = '0;
          if (last) begin
            phase_next = PH_ERROR;
            err_next   = ST_TRUNC;
          end else begin
            phase_next = PH_SHEX;
          end
        end
      end
      default: begin
      end
    endcase

    // whole UTF-8 sequence must land strictly below the limit
    enc  = utf8_encode(cp);
    fits = ({1'b0, emitted} + {14'b0, enc.len}) < {1'b0, limit};
    if (put_cp && cp != '0 && fits) begin
      bundle.bytes  = enc.bytes;
      bundle.nbytes = enc.len;
      emitted_next  = emitted + {13'b0, enc.len};
    end

    if (last) begin
      bundle.has_status = 1'b1;
      bundle.status     = (phase_next == PH_ERROR) ? err_next : ST_OK;
      phase_next   = PH_NORMAL;
      acc_next     = '0;
      cnt_next     = '0;
      hs_next      = '0;
      emitted_next = '0;
      err_next     = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_NORMAL;
      acc     <= '0;
      cnt     <= '0;
      hs      <= '0;
      emitted <= '0;
      err     <= ST_OK;
    end else if (accept) begin
      phase   <= phase_next;
      acc     <= acc_next;
      cnt     <= cnt_next;
      hs      <= hs_next;
      emitted <= emitted_next;
      err     <= err_next;
    end
  end

  a_err_only_in_error: assert property (@(posedge clk) disable iff (rst)
    err != ST_OK |-> phase == PH_ERROR)
    else $error("error code held outside error phase");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && beat.last_byte |=> phase == PH_NORMAL && emitted == 16'd0)
    else $error("string state not cleared after last byte");

  a_quiet_when_done: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE || phase == PH_ERROR) |-> bundle.nbytes == 3'd0)
    else $error("data produced after end of decoding");

endmodule

// File: design/jsu_outq.sv
// Result register: holds one byte's bundle and drains it one beat per cycle while dec_ready is high.
module jsu_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  jsu_pkg::bundle_t   bundle,
  output logic               can_load,
  output logic               dec_valid,
  input  logic               dec_ready,
  output jsu_pkg::out_beat_t dec_data
);
  import jsu_pkg::*;

  logic [MAX_BYTES-1:0][7:0] bytes;
  logic [2:0]                nbytes;
  logic                      has_status;
  status_t                   status;
  logic                      taken;
  logic                      final_beat;

  assign dec_valid  = (nbytes != 3'd0) || has_status;
  assign taken      = dec_valid && dec_ready;
  assign final_beat = (nbytes == 3'd0) || (nbytes == 3'd1 && !has_status);
  assign can_load   = !dec_valid || (taken && final_beat);

  always_comb begin
    dec_data = '0;
    dec_data.status = ST_OK;
    if (nbytes != 3'd0) begin
      dec_data.out_byte = bytes[0];
      dec_data.is_data  = 1'b1;
    end else begin
      dec_data.status      = status;
      dec_data.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nbytes     <= '0;
      has_status <= 1'b0;
    end else if (load) begin
      nbytes     <= bundle.nbytes;
      has_status <= bundle.has_status;
    end else if (taken) begin
      if (nbytes != 3'd0) nbytes <= nbytes - 3'd1;
      else has_status <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes  <= bundle.bytes;
      status <= bundle.status;
    end else if (taken) begin
      bytes <= {8'h00, bytes[MAX_BYTES-1:1]};
    end
  end

  a_depth: assert property (@(posedge clk) disable iff (rst)
    nbytes <= 3'(MAX_BYTES))
    else $error("byte count above bundle size");

  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("bundle overwritten before drained");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    taken && !load && nbytes != 3'd0 |=> nbytes == $past(nbytes) - 3'd1)
    else $error("byte count did not step on a taken beat");

endmodule

// File: dv/json_unescape_checker.sv
// Checker for the JSON string unescaper: predicts decoded beats and compares them.
module json_unescape_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  input  logic               char_ready,
  input  jsu_pkg::in_beat_t  char_data,
  input  logic               dec_valid,
  input  logic               dec_ready,
  input  jsu_pkg::out_beat_t dec_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // decoder state, mirrors the block's per-string state
  phase_t      phase;
  logic [15:0] acc;
  logic [1:0]  ndig;
  logic [9:0]  hi_bits;
  logic [15:0] emitted;
  status_t     err;
  logic [15:0] limit;

  out_beat_t   decoded_q[$];

  initial fail_count = 0;
  initial pending = 0;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  task automatic clear_string();
    phase   = PH_NORMAL;
    acc     = '0;
    ndig    = '0;
    hi_bits = '0;
    emitted = '0;
    err     = ST_OK;
  endtask

  task automatic fail_with(input status_t s);
    err   = s;
    phase = PH_ERROR;
  endtask

  task automatic push_data(input logic [7:0] b);
    decoded_q.push_back('{out_byte: b, is_data: 1'b1, status: ST_OK, last_result: 1'b0});
  endtask

  // UTF-8 encode; the whole sequence must fit strictly below the limit
  task automatic push_code_point(input logic [20:0] cp);
    int len;
    if (cp == '0) return;
    if (cp <= 21'h7F) len = 1;
    else if (cp <= 21'h7FF) len = 2;
    else if (cp <= 21'hFFFF) len = 3;
    else len = 4;
    if (int'(emitted) + len >= int'(limit)) return;
    case (len)
      1: push_data(cp[7:0]);
      2: begin
        push_data({3'b110, cp[10:6]});
        push_data({2'b10, cp[5:0]});
      end
      3: begin
        push_data({4'b1110, cp[15:12]});
        push_data({2'b10, cp[11:6]});
        push_data({2'b10, cp[5:0]});
      end
      default: begin
        push_data({5'b11110, cp[20:18]});
        push_data({2'b10, cp[17:12]});
        push_data({2'b10, cp[11:6]});
        push_data({2'b10, cp[5:0]});
      end
    endcase
    emitted = emitted + 16'(len);
  endtask

  task automatic unescape_byte(input logic [7:0] b, input logic lst);
    int          v;
    logic [7:0]  simple;
    logic        simple_ok;
    logic [20:0] cp;
    case (phase)
      PH_NORMAL: begin
        if (emitted >= limit || b == CH_QUOTE) begin
          phase = PH_DONE;
        end else if (b == CH_BSLASH) begin
          if (lst) fail_with(ST_TRUNC);
          else phase = PH_ESC;
        end else begin
          push_data(b);
          emitted++;
        end
      end
      PH_ESC: begin
        simple_ok = 1'b1;
        simple    = b;
        case (b)
          CH_QUOTE, CH_SLASH, CH_BSLASH: simple = b;
          8'h62: simple = 8'h08;
          8'h66: simple = 8'h0C;
          8'h6E: simple = 8'h0A;
          8'h72: simple = 8'h0D;
          8'h74: simple = 8'h09;
          default: simple_ok = 1'b0;
        endcase
        if (b == CH_U) begin
          acc  = '0;
          ndig = '0;
          if (lst) fail_with(ST_TRUNC);
          else phase = PH_HEX;
        end else if (simple_ok) begin
          if (emitted < limit) begin
            push_data(simple);
            emitted++;
          end
          phase = PH_NORMAL;
        end else begin
          fail_with(ST_BAD_ESC);
        end
      end
      PH_HEX, PH_SHEX: begin
        v = hex_nibble(b);
        if (v < 0) begin
          fail_with(ST_BAD_HEX);
        end else begin
          acc = {acc[11:0], 4'(v)};
          if (ndig < 2'd3) begin
            ndig++;
            if (lst) fail_with(ST_TRUNC);
          end else begin
            ndig = '0;
            if (phase == PH_SHEX) begin
              // low escape is taken as is; only its low 10 bits count
              cp = 21'h10000 + {1'b0, hi_bits, 10'b0} + {11'b0, acc[9:0]};
              push_code_point(cp);
              phase = PH_NORMAL;
            end else if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
              hi_bits = acc[9:0];
              if (lst) fail_with(ST_UNPAIRED);
              else phase = PH_SBS;
            end else begin
              push_code_point({5'b0, acc});
              phase = PH_NORMAL;
            end
          end
        end
      end
      PH_SBS: begin
        if (b != CH_BSLASH) fail_with(ST_UNPAIRED);
        else if (lst) fail_with(ST_TRUNC);
        else phase = PH_SU;
      end
      PH_SU: begin
        if (b != CH_U) begin
          fail_with(ST_UNPAIRED);
        end else begin
          acc  = '0;
          ndig = '0;
          if (lst) fail_with(ST_TRUNC);
          else phase = PH_SHEX;
        end
      end
      default: ;
    endcase
    if (lst) begin
      decoded_q.push_back('{out_byte: 8'h00, is_data: 1'b0,
                            status: (phase == PH_ERROR) ? err : ST_OK,
                            last_result: 1'b1});
      clear_string();
    end
  endtask

  // input beat is predicted before the output beat of the same edge
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      limit = LIMIT_RESET;
      clear_string();
      decoded_q.delete();
    end else begin
      if (cfg_we) limit = cfg_wdata;
      if (char_valid && char_ready) unescape_byte(char_data.in_byte, char_data.last_byte);
      if (dec_valid && dec_ready) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected dec beat byte=%h data=%b status=%0d last=%b", $time,
                   dec_data.out_byte, dec_data.is_data, dec_data.status,
                   dec_data.last_result);
        end else begin
          want = decoded_q.pop_front();
          if (dec_data.out_byte !== want.out_byte || dec_data.is_data !== want.is_data ||
              dec_data.status !== want.status ||
              dec_data.last_result !== want.last_result) begin
            fail_count++;
            $display("%0t: dec mismatch: expected byte=%h data=%b status=%0d last=%b",
                     $time, want.out_byte, want.is_data, want.status, want.last_result);
            $display("%0t:               actual   byte=%h data=%b status=%0d last=%b",
                     $time, dec_data.out_byte, dec_data.is_data, dec_data.status,
                     dec_data.last_result);
          end
        end
      end
    end
    pending <= decoded_q.size();
  end

endmodule

// File: dv/json_string_unescape_utf8_tb.sv
// Testbench top for the JSON string unescaper: stimulus, handshakes and verdict.
module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  typedef logic [7:0] bytes_t[$];

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // second letters of the one-byte escapes
  localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_SLASH, CH_BSLASH,
                                            8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};

  localparam int RANDOM_BEATS  = 430;
  localparam int SETTLE_CYCLES = 8;   // result register drain plus margin
  localparam int MAX_IDLE      = 16;

  logic        clk = 1'b0;
  logic        rst;
  logic        char_valid;
  logic        char_ready;
  in_beat_t    char_data;
  logic        dec_valid;
  logic        dec_ready;
  out_beat_t   dec_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  int          fail_count;
  int          pending;

  // per-string idling modes; set by the stimulus, read by the handshake loops
  bit          tx_gaps;
  bit          rx_stalls;
  int          sent;

  bytes_t      s;
  int          phase_no;
  int          nstr;
  int          npieces;
  int          cut;
  int          mode;
  logic [15:0] lim;

  always #1 clk = ~clk;

  json_string_unescape_utf8 u_top (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_data (char_data),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  json_unescape_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_data (char_data),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // watchdog, well above the slowest legal run
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  // receiver: a fresh stall before every dec beat when stalls are on.
  // ready is only lowered when a stall is drawn, so back-to-back beats
  // never see a low/high pair in the same step.
  initial begin
    int stall;
    dec_ready = 1'b0;
    wait (!rst);
    forever begin
      stall = rx_stalls ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        dec_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dec_ready <= 1'b1;
      do @(posedge clk); while (!dec_valid);
    end
  end

  // one char beat; called at a clock edge, returns at the edge that takes it
  task automatic send_beat(input logic [7:0] b, input logic lst);
    int gap;
    gap = tx_gaps ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= '{in_byte: b, last_byte: lst};
    do @(posedge clk); while (!char_ready);
    sent++;
  endtask

  // a whole string, last_byte on its final byte; idling mode drawn per string
  task automatic send_string(input bytes_t str);
    mode      = $urandom_range(0, 3);
    tx_gaps   = mode[0];
    rx_stalls = mode[1];
    foreach (str[i]) send_beat(str[i], i == str.size() - 1);
  endtask

  // limit writes only once the block has drained and settled
  task automatic set_limit(input logic [15:0] v);
    char_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // hex digit in random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return c;
  endfunction

  task automatic add_hex(ref bytes_t str, input logic [15:0] v);
    for (int i = 3; i >= 0; i--) str.push_back(hex_char(v[i*4 +: 4]));
  endtask

  // one token of string content: mostly well-formed text and escapes,
  // the rest broken escapes and stray quotes
  task automatic add_piece(ref bytes_t str);
    int          kind;
    int          k;
    logic [7:0]  c;
    logic [15:0] v;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // plain text; quotes and backslashes come from the other kinds
      c = 8'($urandom_range(0, 255));
      if (c == CH_QUOTE || c == CH_BSLASH) c = c ^ 8'h01;
      str.push_back(c);
    end else if (kind < 50) begin
      str.push_back(CH_BSLASH);
      str.push_back(ESC_LETTERS[3'($urandom_range(0, 7))]);
    end else if (kind < 70) begin
      // single \uXXXX across the one- to three-byte UTF-8 lengths, \u0000 and lone lows
      case ($urandom_range(0, 5))
        0: v = 16'($urandom_range(16'h0001, 16'h007F));
        1: v = 16'($urandom_range(16'h0080, 16'h07FF));
        2: v = 16'($urandom_range(16'h0800, 16'hD7FF));
        3: v = 16'($urandom_range(16'hDC00, 16'hDFFF));
        4: v = 16'($urandom_range(16'hE000, 16'hFFFF));
        default: v = 16'h0000;
      endcase
      str.push_back(CH_BSLASH);
      str.push_back(CH_U);
      add_hex(str, v);
    end else if (kind < 85) begin
      // surrogate pair; the low half is sometimes any value at all
      str.push_back(CH_BSLASH);
      str.push_back(CH_U);
      add_hex(str, 16'($urandom_range(16'hD800, 16'hDBFF)));
      str.push_back(CH_BSLASH);
      str.push_back(CH_U);
      if ($urandom_range(0, 3) == 0) add_hex(str, 16'($urandom_range(0, 16'hFFFF)));
      else add_hex(str, 16'($urandom_range(16'hDC00, 16'hDFFF)));
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          // unknown escape letter
          do c = 8'($urandom_range(0, 255));
          while (c inside {CH_QUOTE, CH_SLASH, CH_BSLASH, CH_U,
                           8'h62, 8'h66, 8'h6E, 8'h72, 8'h74});
          str.push_back(CH_BSLASH);
          str.push_back(c);
        end
        1: begin
          // non-hex at any digit position of a \u
          str.push_back(CH_BSLASH);
          str.push_back(CH_U);
          k = $urandom_range(0, 3);
          repeat (k) str.push_back(hex_char(4'($urandom_range(0, 15))));
          str.push_back(pick_non_hex());
        end
        2: begin
          // high surrogate not followed by a backslash
          str.push_back(CH_BSLASH);
          str.push_back(CH_U);
          add_hex(str, 16'($urandom_range(16'hD800, 16'hDBFF)));
          do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
          str.push_back(c);
        end
        3: begin
          // high surrogate, backslash, then not a u
          str.push_back(CH_BSLASH);
          str.push_back(CH_U);
          add_hex(str, 16'($urandom_range(16'hD800, 16'hDBFF)));
          str.push_back(CH_BSLASH);
          do c = 8'($urandom_range(0, 255)); while (c == CH_U);
          str.push_back(c);
        end
        4: str.push_back(CH_QUOTE);
        default: begin
          // bad digit inside the low half of a pair
          str.push_back(CH_BSLASH);
          str.push_back(CH_U);
          add_hex(str, 16'($urandom_range(16'hD800, 16'hDBFF)));
          str.push_back(CH_BSLASH);
          str.push_back(CH_U);
          k = $urandom_range(0, 3);
          repeat (k) str.push_back(hex_char(4'($urandom_range(0, 15))));
          str.push_back(pick_non_hex());
        end
      endcase
    end
  endtask

  initial begin
    rst        = 1'b1;
    char_valid = 1'b0;
    char_data  = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    tx_gaps    = 1'b0;
    rx_stalls  = 1'b0;
    sent       = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, at the reset limit:
    // byte extremes, an escaped quote and \u0000 ending exactly on the last digit
    s = '{8'h00, 8'hFF, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_U,
          8'h30, 8'h30, 8'h30, 8'h30};
    send_string(s);
    // surrogate pair with mixed-case digits, four-byte output
    s = '{CH_BSLASH, CH_U, 8'h44, 8'h38, 8'h33, 8'h64,
          CH_BSLASH, CH_U, 8'h64, 8'h45, 8'h30, 8'h30};
    send_string(s);
    // bare quote as the only byte
    s = '{CH_QUOTE};
    send_string(s);
    // unknown escape letter on the last byte
    s = '{CH_BSLASH, 8'h71};
    send_string(s);
    // string cut off right after a backslash
    s = '{CH_BSLASH};
    send_string(s);

    // random strings, grouped into phases that each run at one limit;
    // the first phases pin the extremes of the limit
    phase_no = 0;
    while (sent < 26 + RANDOM_BEATS) begin
      case (phase_no)
        0: lim = 16'd1;
        1: lim = 16'hFFFF;
        default: begin
          case ($urandom_range(0, 5))
            0: lim = 16'($urandom_range(1, 4));
            1: lim = 16'($urandom_range(5, 20));
            2: lim = LIMIT_RESET;
            3: lim = 16'hFFFF;
            4: lim = 16'd1;
            default: lim = 16'($urandom_range(1, 16'hFFFF));
          endcase
        end
      endcase
      set_limit(lim);
      nstr = $urandom_range(2, 6);
      repeat (nstr) begin
        s.delete();
        npieces = $urandom_range(1, 8);
        repeat (npieces) add_piece(s);
        // now and then end the string early, possibly mid-escape
        if ($urandom_range(0, 9) == 0) begin
          cut = $urandom_range(1, s.size());
          while (s.size() > cut) void'(s.pop_back());
        end
        send_string(s);
      end
      phase_no++;
    end

    // let everything drain, then wait SETTLE_CYCLES more for stray beats
    char_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
